FILE: rtl/cfpio_pkg.sv
// Shared types, codes and constants of the CompactFlash PIO sector read sequencer.
`timescale 1ns / 1ps

package cfpio_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int WPS_W            = $clog2(WORDS_PER_SECTOR + 1);

    // Longest burst of results one request can cause: six task-file writes plus one.
    localparam int RES_DEPTH = 7;
    localparam int CNT_W     = $clog2(RES_DEPTH + 1);

    localparam logic [23:0] POLL_LIMIT_RESET = 24'd10000000;
    localparam logic [8:0]  SECTOR_MAX       = 9'd256;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // Card register selects
    localparam logic [3:0] REG_NONE    = 4'd0;
    localparam logic [3:0] REG_DATA    = 4'd0;
    localparam logic [3:0] REG_STATUS  = 4'd1;
    localparam logic [3:0] REG_COMMAND = 4'd2;
    localparam logic [3:0] REG_COUNT   = 4'd4;
    localparam logic [3:0] REG_LBA1    = 4'd5;
    localparam logic [3:0] REG_LBA2    = 4'd6;
    localparam logic [3:0] REG_LBA3    = 4'd7;
    localparam logic [3:0] REG_LBA4    = 4'd8;

    // Status bits and command values
    localparam logic [7:0] STAT_BUSY     = 8'h80;
    localparam logic [7:0] STAT_PRESENT  = 8'h50;
    localparam logic [7:0] STAT_DRQ_RDY  = 8'h58;
    localparam logic [7:0] LBA_HEAD_BITS = 8'hE0;
    localparam logic [7:0] CMD_READ_SECT = 8'h20;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  reg_select;
        logic [15:0] write_value;
        logic [15:0] data_word;
        logic        success;
    } res_t;

    // One request's results, handed from the engine to the output queue
    typedef struct packed {
        logic                        load;
        logic [CNT_W-1:0]            n;
        res_t [RES_DEPTH-1:0]        items;
    } batch_t;

    function automatic res_t mk_res(logic [1:0] kind, logic [3:0] sel,
                                    logic [15:0] wval, logic [15:0] dword,
                                    logic ok);
        res_t r;
        r.kind        = kind;
        r.reg_select  = sel;
        r.write_value = wval;
        r.data_word   = dword;
        r.success     = ok;
        return r;
    endfunction

endpackage

FILE: rtl/cfpio_if.sv
// Valid/ready channel interfaces for requests in and results out.
`timescale 1ns / 1ps

interface cfpio_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [27:0] first_sector;
    logic [8:0]  sector_total;
    logic [15:0] bus_read_value;

    modport source (output valid, opcode, first_sector, sector_total, bus_read_value,
                    input ready);
    modport sink   (input valid, opcode, first_sector, sector_total, bus_read_value,
                    output ready);
endinterface

interface cfpio_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  reg_select;
    logic [15:0] write_value;
    logic [15:0] data_word;
    logic        success;
    logic        last_of_run;

    modport source (output valid, kind, reg_select, write_value, data_word, success,
                    last_of_run, input ready);
    modport sink   (input valid, kind, reg_select, write_value, data_word, success,
                    last_of_run, output ready);
endinterface

FILE: rtl/cf_pio_sector_read_sequencer.sv
// Top level of the CompactFlash PIO sector read sequencer.
// The first result of a request is registered and appears the cycle after the request is accepted.
// Results leave one per cycle while result.ready is high; a request's results leave in order.
// The next request can be taken as early as the cycle the previous request's last result leaves:
// a poll gives one result, a data word response two (word plus next read or done), task-file setup 7.
// Reset clears the sequencer to idle and sets the poll limit to 10000000.
`timescale 1ns / 1ps

module cf_pio_sector_read_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [23:0]     cfg_wdata,
    cfpio_item_if.sink      item,
    cfpio_result_if.source  result
);

    cfpio_pkg::batch_t batch;
    logic              space;

    cfpio_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .space     (space),
        .batch     (batch)
    );

    cfpio_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .batch  (batch),
        .space  (space),
        .result (result)
    );

endmodule

FILE: rtl/cfpio_engine.sv
// Sequencer state and per-request result generation.
`timescale 1ns / 1ps

module cfpio_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [23:0]          cfg_wdata,
    cfpio_item_if.sink           item,
    input  logic                 space,
    output cfpio_pkg::batch_t    batch
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BUSY,
        PH_PRESENT,
        PH_READY,
        PH_DATA
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [23:0]        poll_limit_reg;
    logic [23:0]        poll_count_reg, poll_count_next;
    logic [8:0]         sectors_left_reg, sectors_left_next;
    logic [cfpio_pkg::WPS_W-1:0] words_left_reg, words_left_next;
    logic [27:0]        sector_latch_reg, sector_latch_next;
    logic [8:0]         count_latch_reg, count_latch_next;

    logic               accept;
    logic [23:0]        lim;
    logic [23:0]        poll_inc;
    logic               poll_out;
    logic [8:0]         cnt_sat;
    logic [cfpio_pkg::WPS_W-1:0] wl_dec;
    logic [8:0]         sl_dec;
    logic [7:0]         v8;

    assign item.ready = space;
    assign accept     = item.valid && item.ready;
    assign v8         = item.bus_read_value[7:0];

    assign lim      = (poll_limit_reg == 24'd0) ? 24'd1 : poll_limit_reg;
    assign poll_inc = poll_count_reg + 24'd1;
    assign poll_out = (poll_inc >= lim);
    assign cnt_sat  = (item.sector_total > cfpio_pkg::SECTOR_MAX) ? cfpio_pkg::SECTOR_MAX
                                                                   : item.sector_total;
    assign wl_dec   = (words_left_reg == '0) ? '0 : words_left_reg - 1'b1;
    assign sl_dec   = (sectors_left_reg == 9'd0) ? 9'd0 : sectors_left_reg - 9'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        poll_count_next   = poll_count_reg;
        sectors_left_next = sectors_left_reg;
        words_left_next   = words_left_reg;
        sector_latch_next = sector_latch_reg;
        count_latch_next  = count_latch_reg;
        batch             = '0;
        batch.load        = accept;

        if (accept)
        begin
            if (item.opcode == cfpio_pkg::OP_START)
            begin
                // a start while a read is under way is dropped
                if (phase_reg == PH_IDLE)
                begin
                    sector_latch_next = item.first_sector;
                    count_latch_next  = cnt_sat;
                    sectors_left_next = cnt_sat;
                    words_left_next   = '0;
                    poll_count_next   = 24'd0;
                    phase_next        = PH_BUSY;
                    batch.n           = cfpio_pkg::CNT_W'(1);
                    batch.items[0]    = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                            cfpio_pkg::REG_COMMAND, 16'h0, 16'h0, 1'b0);
                end
            end
            else
            begin
                case (phase_reg)
                    PH_BUSY:
                    begin
                        batch.n = cfpio_pkg::CNT_W'(1);
                        if ((v8 & cfpio_pkg::STAT_BUSY) == 8'h00)
                        begin
                            phase_next      = PH_PRESENT;
                            poll_count_next = 24'd0;
                            batch.items[0]  = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                  cfpio_pkg::REG_STATUS, 16'h0, 16'h0, 1'b0);
                        end
                        else
                        begin
                            poll_count_next = poll_inc;
                            if (poll_out)
                            begin
                                phase_next     = PH_IDLE;
                                batch.items[0] = cfpio_pkg::mk_res(cfpio_pkg::KIND_DONE,
                                                     cfpio_pkg::REG_NONE, 16'h0, 16'h0, 1'b0);
                            end
                            else
                            begin
                                batch.items[0] = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                   cfpio_pkg::REG_COMMAND, 16'h0, 16'h0, 1'b0);
                            end
                        end
                    end
                    PH_PRESENT:
                    begin
                        if ((v8 & cfpio_pkg::STAT_PRESENT) != 8'h00)
                        begin
                            // task file: count (256 goes out as 0), LBA bytes, command
                            batch.n        = cfpio_pkg::CNT_W'(7);
                            batch.items[0] = cfpio_pkg::mk_res(cfpio_pkg::KIND_WRITE,
                                                 cfpio_pkg::REG_COUNT,
                                                 {8'h00, count_latch_reg[7:0]}, 16'h0, 1'b0);
                            batch.items[1] = cfpio_pkg::mk_res(cfpio_pkg::KIND_WRITE,
                                                 cfpio_pkg::REG_LBA1,
                                                 {8'h00, sector_latch_reg[7:0]}, 16'h0, 1'b0);
                            batch.items[2] = cfpio_pkg::mk_res(cfpio_pkg::KIND_WRITE,
                                                 cfpio_pkg::REG_LBA2,
                                                 {8'h00, sector_latch_reg[15:8]}, 16'h0, 1'b0);
                            batch.items[3] = cfpio_pkg::mk_res(cfpio_pkg::KIND_WRITE,
                                                 cfpio_pkg::REG_LBA3,
                                                 {8'h00, sector_latch_reg[23:16]}, 16'h0, 1'b0);
                            batch.items[4] = cfpio_pkg::mk_res(cfpio_pkg::KIND_WRITE,
                                                 cfpio_pkg::REG_LBA4,
                                                 {8'h00, cfpio_pkg::LBA_HEAD_BITS |
                                                  {4'h0, sector_latch_reg[27:24]}},
                                                 16'h0, 1'b0);
                            batch.items[5] = cfpio_pkg::mk_res(cfpio_pkg::KIND_WRITE,
                                                 cfpio_pkg::REG_COMMAND,
                                                 {8'h00, cfpio_pkg::CMD_READ_SECT}, 16'h0, 1'b0);
                            poll_count_next = 24'd0;
                            if (sectors_left_reg == 9'd0)
                            begin
                                phase_next     = PH_IDLE;
                                batch.items[6] = cfpio_pkg::mk_res(cfpio_pkg::KIND_DONE,
                                                     cfpio_pkg::REG_NONE, 16'h0, 16'h0, 1'b1);
                            end
                            else
                            begin
                                phase_next     = PH_READY;
                                batch.items[6] = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                   cfpio_pkg::REG_STATUS, 16'h0, 16'h0, 1'b0);
                            end
                        end
                        else
                        begin
                            batch.n         = cfpio_pkg::CNT_W'(1);
                            poll_count_next = poll_inc;
                            if (poll_out)
                            begin
                                phase_next     = PH_IDLE;
                                batch.items[0] = cfpio_pkg::mk_res(cfpio_pkg::KIND_DONE,
                                                     cfpio_pkg::REG_NONE, 16'h0, 16'h0, 1'b0);
                            end
                            else
                            begin
                                batch.items[0] = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                   cfpio_pkg::REG_STATUS, 16'h0, 16'h0, 1'b0);
                            end
                        end
                    end
                    PH_READY:
                    begin
                        batch.n = cfpio_pkg::CNT_W'(1);
                        if (v8 == cfpio_pkg::STAT_DRQ_RDY)
                        begin
                            phase_next      = PH_DATA;
                            poll_count_next = 24'd0;
                            words_left_next = cfpio_pkg::WPS_W'(cfpio_pkg::WORDS_PER_SECTOR);
                            batch.items[0]  = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                  cfpio_pkg::REG_DATA, 16'h0, 16'h0, 1'b0);
                        end
                        else
                        begin
                            poll_count_next = poll_inc;
                            if (poll_out)
                            begin
                                phase_next     = PH_IDLE;
                                batch.items[0] = cfpio_pkg::mk_res(cfpio_pkg::KIND_DONE,
                                                     cfpio_pkg::REG_NONE, 16'h0, 16'h0, 1'b0);
                            end
                            else
                            begin
                                batch.items[0] = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                   cfpio_pkg::REG_STATUS, 16'h0, 16'h0, 1'b0);
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        batch.n         = cfpio_pkg::CNT_W'(2);
                        batch.items[0]  = cfpio_pkg::mk_res(cfpio_pkg::KIND_DATA,
                                              cfpio_pkg::REG_NONE, 16'h0,
                                              item.bus_read_value, 1'b0);
                        words_left_next = wl_dec;
                        if (wl_dec != '0)
                        begin
                            batch.items[1] = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                 cfpio_pkg::REG_DATA, 16'h0, 16'h0, 1'b0);
                        end
                        else
                        begin
                            sectors_left_next = sl_dec;
                            if (sl_dec == 9'd0)
                            begin
                                phase_next     = PH_IDLE;
                                batch.items[1] = cfpio_pkg::mk_res(cfpio_pkg::KIND_DONE,
                                                     cfpio_pkg::REG_NONE, 16'h0, 16'h0, 1'b1);
                            end
                            else
                            begin
                                phase_next      = PH_READY;
                                poll_count_next = 24'd0;
                                batch.items[1]  = cfpio_pkg::mk_res(cfpio_pkg::KIND_READ,
                                                      cfpio_pkg::REG_STATUS, 16'h0, 16'h0, 1'b0);
                            end
                        end
                    end
                    default:
                    begin
                        // response while idle: dropped
                        batch.n = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            poll_limit_reg   <= cfpio_pkg::POLL_LIMIT_RESET;
            poll_count_reg   <= 24'd0;
            sectors_left_reg <= 9'd0;
            words_left_reg   <= '0;
            sector_latch_reg <= 28'd0;
            count_latch_reg  <= 9'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            poll_count_reg   <= poll_count_next;
            sectors_left_reg <= sectors_left_next;
            words_left_reg   <= words_left_next;
            sector_latch_reg <= sector_latch_next;
            count_latch_reg  <= count_latch_next;
            if (cfg_we)
            begin
                poll_limit_reg <= cfg_wdata;
            end
        end
    end

    a_busy_start_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == cfpio_pkg::OP_START && phase_reg != PH_IDLE)
            |-> (batch.n == '0))
        else $error("start request while busy produced results");

    a_data_has_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (sectors_left_reg != 9'd0))
        else $error("data phase with no sectors left");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && batch.n != '0 && batch.items[0].kind == cfpio_pkg::KIND_DONE)
            |=> (phase_reg == PH_IDLE))
        else $error("engine not idle after timeout");

endmodule

FILE: rtl/cfpio_out_queue.sv
// Result queue: holds one request's results and hands them out one per cycle while result.ready is high.
`timescale 1ns / 1ps

module cfpio_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  cfpio_pkg::batch_t  batch,
    output logic               space,
    cfpio_result_if.source     result
);

    cfpio_pkg::res_t [cfpio_pkg::RES_DEPTH-1:0] list_reg, list_next;
    logic [cfpio_pkg::CNT_W-1:0]                count_reg, count_next;
    logic                                       pop;

    assign pop   = result.valid && result.ready;
    // a new request may load while the last result of the previous one leaves
    assign space = (count_reg == '0) || ((count_reg == cfpio_pkg::CNT_W'(1)) && result.ready);

    assign result.valid       = (count_reg != '0);
    assign result.kind        = list_reg[0].kind;
    assign result.reg_select  = list_reg[0].reg_select;
    assign result.write_value = list_reg[0].write_value;
    assign result.data_word   = list_reg[0].data_word;
    assign result.success     = list_reg[0].success;
    assign result.last_of_run = (count_reg == cfpio_pkg::CNT_W'(1));

    always_comb
    begin
        list_next  = list_reg;
        count_next = count_reg;
        if (batch.load)
        begin
            list_next  = batch.items;
            count_next = batch.n;
        end
        else if (pop)
        begin
            for (int i = 0; i < cfpio_pkg::RES_DEPTH - 1; i++)
            begin
                list_next[i] = list_reg[i + 1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        batch.load |-> ((count_reg == '0) || ((count_reg == cfpio_pkg::CNT_W'(1)) && pop)))
        else $error("results loaded over pending results");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cfpio_pkg::CNT_W'(cfpio_pkg::RES_DEPTH))
        else $error("queue count out of range");

    a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !batch.load) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not advance on a taken result");

endmodule
